[hw/rtl/bone_pose_transform_defines.svh]
// assertion macros for the bone pose transform checker
`ifndef BONE_POSE_TRANSFORM_DEFINES_SVH
`define BONE_POSE_TRANSFORM_DEFINES_SVH
// assert that a property holds each clock outside reset
`define BPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assert a property including during reset
`define BPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[hw/rtl/bpt_pkg.sv]
// shared types, constants and functions of the bone pose transform
`default_nettype none
package bpt_pkg;
  localparam int MaxBonesDefault = 64;
  localparam int CordicSteps = 18;
  localparam logic signed [33:0] CordicGainInv = 34'sd652032874;
  localparam int InBytes = 21;
  localparam int OutBytes = 25;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    begin
      unique case (i)
        0: r = 34'sd536870912;
        1: r = 34'sd316933406;
        2: r = 34'sd167458907;
        3: r = 34'sd85004756;
        4: r = 34'sd42667331;
        5: r = 34'sd21354465;
        6: r = 34'sd10679838;
        7: r = 34'sd5340245;
        8: r = 34'sd2670163;
        9: r = 34'sd1335087;
        10: r = 34'sd667544;
        11: r = 34'sd333772;
        12: r = 34'sd166886;
        13: r = 34'sd83443;
        14: r = 34'sd41722;
        15: r = 34'sd20861;
        16: r = 34'sd10430;
        default: r = 34'sd5215;
      endcase
      return r;
    end
  endfunction

  // saturate a 64 bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  // round half up the cordic vector to q1.14 and clamp to [0, 16384]
  function automatic logic signed [15:0] unit_round(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [15:0] r;
    begin
      t = (v + 34'sd32768) >>> 16;
      if (t < 0) r = 16'sd0;
      else if (t > 34'sd16384) r = 16'sd16384;
      else r = t[15:0];
      return r;
    end
  endfunction

  typedef struct packed {
    logic [1:0] quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_lane_t;
endpackage
`default_nettype wire

[hw/rtl/bpt_cordic.sv]
// pipelined quarter-turn cordic with quadrant fold, stall by enable
`default_nettype none
module bpt_cordic (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [16:0] phase,
  output logic signed [15:0] cos_q,
  output logic signed [15:0] sin_q
);
  import bpt_pkg::*;

  cordic_lane_t lane [CordicSteps+1];
  logic signed [15:0] c0;
  logic signed [15:0] s0;

  always_comb begin
    lane[0].quad = phase[16:15];
    lane[0].x = CordicGainInv;
    lane[0].y = '0;
    lane[0].z = {4'b0, phase[14:0], 15'b0};
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        lane[i+1].quad <= lane[i].quad;
        if (!lane[i].z[33]) begin
          lane[i+1].x <= lane[i].x - (lane[i].y >>> i);
          lane[i+1].y <= lane[i].y + (lane[i].x >>> i);
          lane[i+1].z <= lane[i].z - atan_turn(i);
        end else begin
          lane[i+1].x <= lane[i].x + (lane[i].y >>> i);
          lane[i+1].y <= lane[i].y - (lane[i].x >>> i);
          lane[i+1].z <= lane[i].z + atan_turn(i);
        end
      end
    end
  end

  assign c0 = unit_round(lane[CordicSteps].x);
  assign s0 = unit_round(lane[CordicSteps].y);

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (lane[CordicSteps].quad)
        2'd0: begin cos_q <= c0;  sin_q <= s0;  end
        2'd1: begin cos_q <= -s0; sin_q <= c0; end
        2'd2: begin cos_q <= -c0; sin_q <= -s0; end
        default: begin cos_q <= s0; sin_q <= -c0; end
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/bone_pose_transform.sv]
// top level: bone rest/pose pair to rotation matrix and dual quaternion
//
// channel  dir  bits  fields (low bit up)
// s_axis   in   168   slot_index, rest_x, rest_y, rest_angle, posed_x, posed_y,
//                     posed_angle, 2 pad bits
// m_axis   out  200   out_slot, rot_cos, rot_sin, shift_x, shift_y, quat_w, quat_z,
//                     dual_y, dual_z, 2 pad bits
//
// one item per cycle while the output is free; 26 register stages: 1 input stage,
// 19 cordic stages, 6 multiply/round stages for translation and dual part
// the whole pipe advances together when the output register is free or taken
// rst clears valid bits only; payload registers hold no reset
`default_nettype none
module bone_pose_transform #(
  parameter int MAX_BONES = bpt_pkg::MaxBonesDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // slot_index, rest_x, rest_y, rest_angle, posed_x, posed_y, posed_angle
  input  wire logic [bpt_pkg::InBytes*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // out_slot, rot_cos, rot_sin, shift_x, shift_y, quat_w, quat_z, dual_y, dual_z
  output logic [bpt_pkg::OutBytes*8-1:0] m_axis_tdata
);
  import bpt_pkg::*;

  localparam int Lat = CordicSteps + 8;
  localparam int SlotW = 6;
  localparam logic [SlotW-1:0] SlotMax = SlotW'(((MAX_BONES > 64) ? 64 : MAX_BONES) - 1);

  logic en;
  logic [Lat-1:0] vld;

  // input fields
  logic [5:0] in_slot;
  logic [15:0] ra, pa, d;
  assign in_slot = s_axis_tdata[5:0];
  assign ra = s_axis_tdata[85:70];
  assign pa = s_axis_tdata[165:150];
  assign d = pa - ra;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end

  // stage 0: register operands
  logic [5:0] slot0;
  logic signed [31:0] rx0, ry0, px0, py0;
  logic [16:0] ph_full, ph_half;
  always_ff @(posedge clk) begin
    if (en) begin
      slot0 <= (in_slot > SlotMax) ? SlotMax : in_slot;
      rx0 <= s_axis_tdata[37:6];
      ry0 <= s_axis_tdata[69:38];
      px0 <= s_axis_tdata[117:86];
      py0 <= s_axis_tdata[149:118];
      ph_full <= {d, 1'b0};
      ph_half <= d[15] ? {1'b1, d} : {1'b0, d};
    end
  end

  // operand delay line alongside the cordic (19 stages)
  localparam int Dly = CordicSteps + 1;
  logic [5:0] slot_d [Dly];
  logic signed [31:0] rx_d [Dly], ry_d [Dly], px_d [Dly], py_d [Dly];
  always_ff @(posedge clk) begin
    if (en) begin
      slot_d[0] <= slot0; rx_d[0] <= rx0; ry_d[0] <= ry0;
      px_d[0] <= px0; py_d[0] <= py0;
      for (int k = 1; k < Dly; k++) begin
        slot_d[k] <= slot_d[k-1]; rx_d[k] <= rx_d[k-1]; ry_d[k] <= ry_d[k-1];
        px_d[k] <= px_d[k-1]; py_d[k] <= py_d[k-1];
      end
    end
  end

  logic signed [15:0] rc, rs, qw, qz;
  bpt_cordic u_rot (.clk, .en, .phase(ph_full), .cos_q(rc), .sin_q(rs));
  bpt_cordic u_half (.clk, .en, .phase(ph_half), .cos_q(qw), .sin_q(qz));

  // translation and dual part: products, sums, round and saturate
  logic signed [47:0] p_cx, p_sy, p_sx, p_cy;
  logic signed [63:0] p_px, p_py;
  logic signed [63:0] t_x, t_y;
  logic signed [31:0] tx, ty;
  logic signed [15:0] rc_a [3], rs_a [3], qw_a [6], qz_a [6];
  logic [5:0] slot_a [6];
  logic signed [47:0] m_xw, m_yz, m_yw, m_xz;
  logic signed [63:0] s_dy, s_dz;
  logic signed [31:0] dy, dz;
  logic signed [31:0] tx_b [3], ty_b [3];

  always_ff @(posedge clk) begin
    if (en) begin
      // t1: multiply
      p_cx <= rc * rx_d[Dly-1];
      p_sy <= rs * ry_d[Dly-1];
      p_sx <= rs * rx_d[Dly-1];
      p_cy <= rc * ry_d[Dly-1];
      p_px <= 64'(px_d[Dly-1]) <<< 14;
      p_py <= 64'(py_d[Dly-1]) <<< 14;
      rc_a[0] <= rc; rs_a[0] <= rs; qw_a[0] <= qw; qz_a[0] <= qz;
      slot_a[0] <= slot_d[Dly-1];
      // t2: combine
      t_x <= p_px - (64'(p_cx) - 64'(p_sy)) + 64'sd8192;
      t_y <= p_py - (64'(p_sx) + 64'(p_cy)) + 64'sd8192;
      rc_a[1] <= rc_a[0]; rs_a[1] <= rs_a[0]; qw_a[1] <= qw_a[0]; qz_a[1] <= qz_a[0];
      slot_a[1] <= slot_a[0];
      // t3: round and saturate
      tx <= sat32(t_x >>> 14);
      ty <= sat32(t_y >>> 14);
      rc_a[2] <= rc_a[1]; rs_a[2] <= rs_a[1]; qw_a[2] <= qw_a[1]; qz_a[2] <= qz_a[1];
      slot_a[2] <= slot_a[1];
      // d1: dual products
      m_xw <= tx * qw_a[2];
      m_yz <= ty * qz_a[2];
      m_yw <= ty * qw_a[2];
      m_xz <= tx * qz_a[2];
      tx_b[0] <= tx; ty_b[0] <= ty;
      qw_a[3] <= qw_a[2]; qz_a[3] <= qz_a[2];
      slot_a[3] <= slot_a[2];
      // d2: sums
      s_dy <= 64'(m_xw) + 64'(m_yz) + 64'sd16384;
      s_dz <= 64'(m_yw) - 64'(m_xz) + 64'sd16384;
      tx_b[1] <= tx_b[0]; ty_b[1] <= ty_b[0];
      qw_a[4] <= qw_a[3]; qz_a[4] <= qz_a[3];
      slot_a[4] <= slot_a[3];
      // d3: round and saturate
      dy <= sat32(s_dy >>> 15);
      dz <= sat32(s_dz >>> 15);
      tx_b[2] <= tx_b[1]; ty_b[2] <= ty_b[1];
      qw_a[5] <= qw_a[4]; qz_a[5] <= qz_a[4];
      slot_a[5] <= slot_a[4];
    end
  end

  logic signed [15:0] rc_o, rs_o;
  always_ff @(posedge clk) begin
    if (en) begin
      rc_o <= rc_a[2]; rs_o <= rs_a[2];
    end
  end
  logic signed [15:0] rc_o2, rs_o2, rc_o3, rs_o3;
  always_ff @(posedge clk) begin
    if (en) begin
      rc_o2 <= rc_o; rs_o2 <= rs_o; rc_o3 <= rc_o2; rs_o3 <= rs_o2;
    end
  end

  assign m_axis_tdata = {2'b0, dz, dy, qz_a[5], qw_a[5], ty_b[2], tx_b[2],
                         rs_o3, rc_o3, slot_a[5]};
endmodule
`default_nettype wire

[hw/rtl/bpt_checker.sv]
// port-level checker for the bone pose transform, bound to the top level
`default_nettype none
`include "bone_pose_transform_defines.svh"
module bpt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [bpt_pkg::OutBytes*8-1:0] m_axis_tdata
);
  import bpt_pkg::*;
  `BPT_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output item dropped or changed while stalled")
  `BPT_ASSERT(a_ready, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")
  `BPT_ASSERT(a_free, !m_axis_tvalid |-> s_axis_tready, "input refused while output empty")
  `BPT_ASSERT_ALWAYS(a_rst, rst |=> !m_axis_tvalid, "output valid after reset")
endmodule
bind bone_pose_transform bpt_checker u_bpt_checker (.*);
`default_nettype wire
